@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the multiply/divide unit.
// Each macro checks a property on the rising edge of clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that must hold on every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mdu_pkg.sv @@
// Package of the multiply/divide unit: operation and width codes, error codes
// and the pipeline stage record. Depends on nothing.
package mdu_pkg;

	typedef enum logic [1:0] {
		CMD_MUL  = 2'd0,
		CMD_IMUL = 2'd1,
		CMD_DIV  = 2'd2,
		CMD_IDIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		WID_8  = 2'd0,
		WID_16 = 2'd1,
		WID_32 = 2'd2
	} wid_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	localparam int unsigned DivSteps = 32;

	// Operands after width masking, sign handling and magnitude forming.
	typedef struct packed {
		cmd_t        cmd;
		wid_t        wid;
		logic [63:0] x;      // extended multiplicand, or dividend magnitude
		logic [32:0] y;      // extended multiplier, or divisor magnitude
		logic        nneg;   // dividend negative
		logic        qneg;   // quotient negative
		logic        bzero;  // divisor is zero
	} pre_t;

	// Record carried through the divide step stages.
	typedef struct packed {
		cmd_t        cmd;
		wid_t        wid;
		logic        nneg;
		logic        qneg;
		err_t        err;
		logic [31:0] rem;    // partial remainder, or high product word
		logic [31:0] ql;     // dividend bits shifting out, quotient shifting in
		logic [31:0] dvsr;
	} div_t;

endpackage

@@ hw/rtl/x86_multiply_divide_unit_core.sv @@
// Pipeline stages: the operand stage, the multiply or divide setup stage,
// 32 restoring divide steps and the result stage.
// Throughput: one transaction per cycle; the whole pipeline advances whenever
// the output register is empty or its result is taken, so nothing is lost or repeated.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on mdu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module x86_multiply_divide_unit_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // operand_a [31:0], operand_b [63:32], dividend_high [95:64]
	input  logic [3:0]   s_tuser,   // cmd [1:0], width_sel [3:2]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // lo_word [31:0], hi_word [63:32]
	output logic [2:0]   m_tuser    // carry_overflow [0], divide_error [2:1]
);

	// A single enable moves every stage at once. The output register holds a
	// finished result until it is taken; while it is empty or being taken the
	// pipeline shifts, so a new transaction can enter on every cycle.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------------------------------------------------------------
	// Stage 1: mask the operands to the width, sign extend for a signed
	// multiply, and form dividend and divisor magnitudes for a divide.
	// ---------------------------------------------------------------------
	mdu_pkg::pre_t pre_d;
	mdu_pkg::pre_t pre_s1;
	logic          v_s1;

	always_comb begin
		logic [31:0] a_in, b_in, h_in, m32, a_m, b_m, h_m, bmag;
		logic [63:0] n, m64, nmag;
		logic        sgn, a_sg, b_sg, h_sg;
		logic [32:0] ax, bx;
		a_in = s_tdata[31:0];
		b_in = s_tdata[63:32];
		h_in = s_tdata[95:64];
		pre_d.cmd = mdu_pkg::cmd_t'(s_tuser[1:0]);
		case (s_tuser[3:2])
			mdu_pkg::WID_8:  pre_d.wid = mdu_pkg::WID_8;
			mdu_pkg::WID_16: pre_d.wid = mdu_pkg::WID_16;
			default:         pre_d.wid = mdu_pkg::WID_32;
		endcase
		case (pre_d.wid)
			mdu_pkg::WID_8: begin
				m32 = 32'h0000_00FF;
				m64 = 64'h0000_0000_0000_FFFF;
			end
			mdu_pkg::WID_16: begin
				m32 = 32'h0000_FFFF;
				m64 = 64'h0000_0000_FFFF_FFFF;
			end
			default: begin
				m32 = 32'hFFFF_FFFF;
				m64 = 64'hFFFF_FFFF_FFFF_FFFF;
			end
		endcase
		a_m = a_in & m32;
		b_m = b_in & m32;
		h_m = h_in & m32;
		case (pre_d.wid)
			mdu_pkg::WID_8: begin
				a_sg = a_m[7];
				b_sg = b_m[7];
				h_sg = h_m[7];
				n    = {48'd0, h_m[7:0], a_m[7:0]};
			end
			mdu_pkg::WID_16: begin
				a_sg = a_m[15];
				b_sg = b_m[15];
				h_sg = h_m[15];
				n    = {32'd0, h_m[15:0], a_m[15:0]};
			end
			default: begin
				a_sg = a_m[31];
				b_sg = b_m[31];
				h_sg = h_m[31];
				n    = {h_m, a_m};
			end
		endcase
		sgn = (pre_d.cmd == mdu_pkg::CMD_IMUL) || (pre_d.cmd == mdu_pkg::CMD_IDIV);
		ax  = {1'b0, a_m} | ({33{sgn && a_sg}} & ~{1'b0, m32});
		bx  = {1'b0, b_m} | ({33{sgn && b_sg}} & ~{1'b0, m32});
		pre_d.nneg  = sgn && h_sg;
		pre_d.qneg  = sgn && (h_sg != b_sg);
		pre_d.bzero = (b_m == 32'd0);
		nmag = pre_d.nneg ? ((64'd0 - n) & m64) : n;
		bmag = (sgn && b_sg) ? ((32'd0 - b_m) & m32) : b_m;
		if (pre_d.cmd == mdu_pkg::CMD_MUL || pre_d.cmd == mdu_pkg::CMD_IMUL) begin
			pre_d.x = {31'd0, ax};
			pre_d.y = bx;
		end else begin
			pre_d.x = nmag;
			pre_d.y = {1'b0, bmag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s1 <= pre_d;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: the multiply, or the divide setup. A divide by zero, or one whose
	// high part already reaches the divisor and so cannot give a quotient that
	// fits, is flagged here; otherwise 32 restoring steps give the exact quotient.
	// ---------------------------------------------------------------------
	mdu_pkg::div_t div_d;
	mdu_pkg::div_t div_s [mdu_pkg::DivSteps + 1];
	logic          v_div_s [mdu_pkg::DivSteps + 1];

	always_comb begin
		logic [65:0] prod;
		logic [63:0] hi_part;
		prod = $signed(pre_s1.x[32:0]) * $signed(pre_s1.y);
		case (pre_s1.wid)
			mdu_pkg::WID_8:  hi_part = {8'd0, pre_s1.x[63:8]};
			mdu_pkg::WID_16: hi_part = {16'd0, pre_s1.x[63:16]};
			default:         hi_part = {32'd0, pre_s1.x[63:32]};
		endcase
		div_d.cmd  = pre_s1.cmd;
		div_d.wid  = pre_s1.wid;
		div_d.nneg = pre_s1.nneg;
		div_d.qneg = pre_s1.qneg;
		div_d.dvsr = pre_s1.y[31:0];
		if (pre_s1.cmd == mdu_pkg::CMD_MUL || pre_s1.cmd == mdu_pkg::CMD_IMUL) begin
			div_d.err = mdu_pkg::ERR_NONE;
			div_d.rem = prod[63:32];
			div_d.ql  = prod[31:0];
		end else begin
			if (pre_s1.bzero) begin
				div_d.err = mdu_pkg::ERR_DIV_ZERO;
			end else if (hi_part >= {32'd0, pre_s1.y[31:0]}) begin
				div_d.err = mdu_pkg::ERR_OVERFLOW;
			end else begin
				div_d.err = mdu_pkg::ERR_NONE;
			end
			div_d.rem = pre_s1.x[63:32];
			div_d.ql  = pre_s1.x[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_div_s[0] <= 1'b0;
		end else if (adv) begin
			v_div_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_d;
		end
	end

	// ---------------------------------------------------------------------
	// Divide steps: each stage shifts one dividend bit into the partial
	// remainder and subtracts the divisor when it fits. Multiplies and
	// flagged divides pass through unchanged.
	// ---------------------------------------------------------------------
	for (genvar k = 1; k <= mdu_pkg::DivSteps; k++) begin : g_step
		mdu_pkg::div_t nxt;

		always_comb begin
			logic [32:0] t;
			logic [32:0] diff;
			logic        run;
			nxt  = div_s[k-1];
			t    = {div_s[k-1].rem, div_s[k-1].ql[31]};
			diff = t - {1'b0, div_s[k-1].dvsr};
			run  = (div_s[k-1].cmd == mdu_pkg::CMD_DIV || div_s[k-1].cmd == mdu_pkg::CMD_IDIV)
				&& (div_s[k-1].err == mdu_pkg::ERR_NONE);
			if (run) begin
				if (!diff[32]) begin
					nxt.rem = diff[31:0];
					nxt.ql  = {div_s[k-1].ql[30:0], 1'b1};
				end else begin
					nxt.rem = t[31:0];
					nxt.ql  = {div_s[k-1].ql[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div_s[k] <= 1'b0;
			end else if (adv) begin
				v_div_s[k] <= v_div_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= nxt;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result stage: split the product by width and set carry/overflow, or
	// apply the signs to quotient and remainder and check the signed range.
	// Any divide error zeroes both result words.
	// ---------------------------------------------------------------------
	mdu_pkg::div_t fin;
	logic [31:0]   lo_d, hi_d;
	logic          cf_d;
	mdu_pkg::err_t err_d;

	assign fin = div_s[mdu_pkg::DivSteps];

	always_comb begin
		logic [63:0] p;
		logic [31:0] m32, lim, q, r;
		logic        fits;
		p = {fin.rem, fin.ql};
		case (fin.wid)
			mdu_pkg::WID_8: begin
				m32  = 32'h0000_00FF;
				lim  = 32'h0000_007F;
				fits = (p[63:7] == {57{1'b0}}) || (p[63:7] == {57{1'b1}});
				lo_d = {24'd0, p[7:0]};
				hi_d = {24'd0, p[15:8]};
			end
			mdu_pkg::WID_16: begin
				m32  = 32'h0000_FFFF;
				lim  = 32'h0000_7FFF;
				fits = (p[63:15] == {49{1'b0}}) || (p[63:15] == {49{1'b1}});
				lo_d = {16'd0, p[15:0]};
				hi_d = {16'd0, p[31:16]};
			end
			default: begin
				m32  = 32'hFFFF_FFFF;
				lim  = 32'h7FFF_FFFF;
				fits = (p[63:31] == {33{1'b0}}) || (p[63:31] == {33{1'b1}});
				lo_d = p[31:0];
				hi_d = p[63:32];
			end
		endcase
		q     = fin.ql;
		r     = fin.rem;
		cf_d  = 1'b0;
		err_d = fin.err;
		case (fin.cmd)
			mdu_pkg::CMD_MUL: begin
				cf_d = (hi_d != 32'd0);
			end
			mdu_pkg::CMD_IMUL: begin
				cf_d = !fits;
			end
			default: begin
				// A negative quotient may reach one past the positive limit.
				if (err_d == mdu_pkg::ERR_NONE && fin.cmd == mdu_pkg::CMD_IDIV
						&& q > (lim + {31'd0, fin.qneg})) begin
					err_d = mdu_pkg::ERR_OVERFLOW;
				end
				lo_d = (fin.qneg ? (32'd0 - q) : q) & m32;
				hi_d = (fin.nneg ? (32'd0 - r) : r) & m32;
				if (err_d != mdu_pkg::ERR_NONE) begin
					lo_d = 32'd0;
					hi_d = 32'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_div_s[mdu_pkg::DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {hi_d, lo_d};
			m_tuser <= {err_d, cf_d};
		end
	end

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`ASSERT_ALWAYS(a_err_zero_result,
		!m_tvalid || m_tuser[2:1] == mdu_pkg::ERR_NONE || m_tdata == 64'd0,
		"divide error with nonzero result")
	`ASSERT_ALWAYS(a_cf_err_exclusive,
		!m_tvalid || !m_tuser[0] || m_tuser[2:1] == mdu_pkg::ERR_NONE,
		"carry/overflow and divide error both set")
	`ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v_s1,
		"accepted transaction did not enter the pipeline")
	`ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"stalled result changed")

endmodule
